// ===== design/ow_pkg.sv =====
`timescale 1ns / 1ps

package ow_pkg;

    // Fixed byte size of the bus protocol.
    localparam int BITS_PER_BYTE = 8;

    // Bus phases.
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_REC  = 4'd3;
    localparam logic [3:0] PH_SLOT_LOW = 4'd4;
    localparam logic [3:0] PH_WR_HOLD  = 4'd5;
    localparam logic [3:0] PH_RD_WAIT  = 4'd6;
    localparam logic [3:0] PH_RD_REC   = 4'd7;
    localparam logic [3:0] PH_GAP      = 4'd8;

    // Command codes.
    localparam logic [2:0] CMD_IDLE   = 3'd0;
    localparam logic [2:0] CMD_RESET  = 3'd1;
    localparam logic [2:0] CMD_WRBYTE = 3'd2;
    localparam logic [2:0] CMD_RDBYTE = 3'd3;
    localparam logic [2:0] CMD_WRBIT  = 3'd4;
    localparam logic [2:0] CMD_RDBIT  = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] REG_TICKS_PER_US  = 3'd0;
    localparam logic [2:0] REG_RESET_LOW     = 3'd1;
    localparam logic [2:0] REG_PRESENCE_WAIT = 3'd2;
    localparam logic [2:0] REG_RESET_REC     = 3'd3;
    localparam logic [2:0] REG_SLOT_LOW      = 3'd4;
    localparam logic [2:0] REG_WRITE_SLOT    = 3'd5;
    localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
    localparam logic [2:0] REG_READ_REC      = 3'd7;

    // Register reset values.
    localparam logic [9:0] RST_TICKS_PER_US  = 10'd1;
    localparam logic [9:0] RST_RESET_LOW     = 10'd480;
    localparam logic [7:0] RST_PRESENCE_WAIT = 8'd60;
    localparam logic [9:0] RST_RESET_REC     = 10'd420;
    localparam logic [3:0] RST_SLOT_LOW      = 4'd1;
    localparam logic [7:0] RST_WRITE_SLOT    = 8'd60;
    localparam logic [5:0] RST_READ_SAMPLE   = 6'd14;
    localparam logic [7:0] RST_READ_REC      = 8'd45;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] wr_data;
        logic       line_in;
    } t_ow_in;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_data;
        logic       presence_level;
        logic       rejected;
    } t_ow_out;

endpackage

// ===== design/one_wire_bus_master.sv =====
`timescale 1ns / 1ps

// One-wire bus master, stepped by one input transaction per bus clock cycle.
// Input channel: i_in_valid / o_in_stall carry a command code, a write byte
// and the sampled line level. Each accepted transaction advances the bus
// timing by one step and produces exactly one output transaction.
// Output channel: o_out_valid / i_out_stall carry the line drive, busy, done,
// the last read byte, the presence level and a rejected flag.
// An accepted transaction's result is registered in the output register, or
// in the skid register while the receiver stalls. Throughput is one
// transaction per cycle while o_in_stall is low; each step is a single pass
// of counter and compare logic between the input and the output register.
// When the receiver stalls, one extra result is held in a skid register, so
// the transaction arriving in the same cycle is still taken; o_in_stall then
// rises until the skid register drains. Results are never dropped.
// Reset (synchronous, active low) loads the timing registers with their defaults,
// returns the bus to idle and empties both output registers. Configuration is a
// plain write port; the user must write it only while the block is idle, unchecked.
module one_wire_bus_master
    import ow_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_ow_in      i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_ow_out     o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_data
);

    // Timing registers.
    logic [9:0] r_ticks_per_us;
    logic [9:0] r_reset_low;
    logic [7:0] r_presence_wait;
    logic [9:0] r_reset_rec;
    logic [3:0] r_slot_low;
    logic [7:0] r_write_slot;
    logic [5:0] r_read_sample;
    logic [7:0] r_read_rec;

    // Bus state.
    logic [3:0] r_phase,     n_phase;
    logic [2:0] r_kind,      n_kind;
    logic [9:0] r_us,        n_us;
    logic [9:0] r_presc,     n_presc;
    logic [3:0] r_bits_left, n_bits_left;
    logic [7:0] r_shift,     n_shift;
    logic       r_presence,  n_presence;
    logic [7:0] r_rd_result, n_rd_result;

    // Output register and skid register.
    logic    r_out_valid;
    t_ow_out r_out_data;
    logic    r_skid_valid;
    t_ow_out r_skid_data;

    logic    in_accept;
    logic    out_take;
    t_ow_out step_out;
    logic    step_done;
    logic    step_rejected;
    logic    step_drive;

    // A register that holds zero behaves as one.
    function automatic logic [9:0] at_least_one(input logic [9:0] v);
        return (v == 10'd0) ? 10'd1 : v;
    endfunction

    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // One bus cycle of the sequencer.
    always_comb begin
        logic       is_cmd;
        logic       is_read;
        logic       expired;
        logic [9:0] presc_inc;
        logic [9:0] us_dec;
        logic [3:0] bits_dec;

        n_phase     = r_phase;
        n_kind      = r_kind;
        n_us        = r_us;
        n_presc     = r_presc;
        n_bits_left = r_bits_left;
        n_shift     = r_shift;
        n_presence  = r_presence;
        n_rd_result = r_rd_result;
        step_done     = 1'b0;
        step_rejected = 1'b0;
        expired       = 1'b0;

        is_cmd   = (i_in_data.func >= CMD_RESET) && (i_in_data.func <= CMD_RDBIT);
        is_read  = (r_kind == CMD_RDBYTE) || (r_kind == CMD_RDBIT);
        presc_inc = r_presc + 10'd1;
        us_dec    = r_us - 10'd1;
        bits_dec  = r_bits_left - 4'd1;

        if (r_phase == PH_IDLE) begin
            if (is_cmd) begin
                n_kind  = i_in_data.func;
                n_presc = 10'd0;
                if (i_in_data.func == CMD_RESET) begin
                    n_phase = PH_RST_LOW;
                    n_us    = at_least_one(r_reset_low);
                end else begin
                    case (i_in_data.func)
                        CMD_WRBYTE: begin
                            n_shift     = i_in_data.wr_data;
                            n_bits_left = 4'(BITS_PER_BYTE);
                        end
                        CMD_WRBIT: begin
                            n_shift     = {7'd0, i_in_data.wr_data[0]};
                            n_bits_left = 4'd1;
                        end
                        CMD_RDBYTE: begin
                            n_shift     = 8'd0;
                            n_bits_left = 4'(BITS_PER_BYTE);
                        end
                        default: begin
                            n_shift     = 8'd0;
                            n_bits_left = 4'd1;
                        end
                    endcase
                    n_phase = PH_SLOT_LOW;
                    n_us    = at_least_one({6'd0, r_slot_low});
                end
            end
        end else begin
            step_rejected = is_cmd;
            if (r_phase == PH_GAP) begin
                n_phase = PH_SLOT_LOW;
                n_us    = at_least_one({6'd0, r_slot_low});
                n_presc = 10'd0;
            end else begin
                n_presc = presc_inc;
                if (presc_inc >= at_least_one(r_ticks_per_us)) begin
                    n_presc = 10'd0;
                    n_us    = us_dec;
                    expired = (us_dec == 10'd0);
                end
                if (expired) begin
                    unique case (r_phase)
                        PH_RST_LOW: begin
                            n_phase = PH_RST_WAIT;
                            n_us    = at_least_one({2'd0, r_presence_wait});
                            n_presc = 10'd0;
                        end
                        PH_RST_WAIT: begin
                            n_presence = i_in_data.line_in;
                            n_phase    = PH_RST_REC;
                            n_us       = at_least_one(r_reset_rec);
                            n_presc    = 10'd0;
                        end
                        PH_RST_REC: begin
                            n_phase   = PH_IDLE;
                            step_done = 1'b1;
                        end
                        PH_SLOT_LOW: begin
                            n_presc = 10'd0;
                            if (is_read) begin
                                n_phase = PH_RD_WAIT;
                                n_us    = at_least_one({4'd0, r_read_sample});
                            end else begin
                                n_phase = PH_WR_HOLD;
                                n_us    = at_least_one({2'd0, r_write_slot});
                            end
                        end
                        PH_RD_WAIT: begin
                            n_shift = {i_in_data.line_in, r_shift[7:1]};
                            n_phase = PH_RD_REC;
                            n_us    = at_least_one({2'd0, r_read_rec});
                            n_presc = 10'd0;
                        end
                        PH_WR_HOLD, PH_RD_REC: begin
                            // End of a bit slot: writes shift out the bit just sent.
                            if (!is_read) begin
                                n_shift = {1'b0, r_shift[7:1]};
                            end
                            n_bits_left = bits_dec;
                            if (bits_dec == 4'd0) begin
                                if (is_read) begin
                                    n_rd_result = r_shift;
                                end
                                n_phase   = PH_IDLE;
                                step_done = 1'b1;
                            end else begin
                                n_phase = PH_GAP;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
        end

        // The line drive follows the phase entered in this cycle.
        if ((n_phase == PH_RST_LOW) || (n_phase == PH_SLOT_LOW)) begin
            step_drive = 1'b1;
        end else if (n_phase == PH_WR_HOLD) begin
            step_drive = ~n_shift[0];
        end else begin
            step_drive = 1'b0;
        end

        step_out.drive_low      = step_drive;
        step_out.busy_res       = (n_phase != PH_IDLE);
        step_out.done_res       = step_done;
        step_out.rd_data        = n_rd_result;
        step_out.presence_level = n_presence;
        step_out.rejected       = step_rejected;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_us  <= RST_TICKS_PER_US;
            r_reset_low     <= RST_RESET_LOW;
            r_presence_wait <= RST_PRESENCE_WAIT;
            r_reset_rec     <= RST_RESET_REC;
            r_slot_low      <= RST_SLOT_LOW;
            r_write_slot    <= RST_WRITE_SLOT;
            r_read_sample   <= RST_READ_SAMPLE;
            r_read_rec      <= RST_READ_REC;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TICKS_PER_US:  r_ticks_per_us  <= i_cfg_data;
                REG_RESET_LOW:     r_reset_low     <= i_cfg_data;
                REG_PRESENCE_WAIT: r_presence_wait <= i_cfg_data[7:0];
                REG_RESET_REC:     r_reset_rec     <= i_cfg_data;
                REG_SLOT_LOW:      r_slot_low      <= i_cfg_data[3:0];
                REG_WRITE_SLOT:    r_write_slot    <= i_cfg_data[7:0];
                REG_READ_SAMPLE:   r_read_sample   <= i_cfg_data[5:0];
                REG_READ_REC:      r_read_rec      <= i_cfg_data[7:0];
                default:           r_read_rec      <= r_read_rec;
            endcase
        end
    end

    // Bus state advances only on an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_kind      <= CMD_IDLE;
            r_us        <= 10'd0;
            r_presc     <= 10'd0;
            r_bits_left <= 4'd0;
            r_shift     <= 8'd0;
            r_presence  <= 1'b1;
            r_rd_result <= 8'd0;
        end else if (in_accept) begin
            r_phase     <= n_phase;
            r_kind      <= n_kind;
            r_us        <= n_us;
            r_presc     <= n_presc;
            r_bits_left <= n_bits_left;
            r_shift     <= n_shift;
            r_presence  <= n_presence;
            r_rd_result <= n_rd_result;
        end
    end

    // Output register with a one-entry skid stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out_data <= step_out;
            end else begin
                r_skid_data <= step_out;
            end
        end
    end

    // The skid stage only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register valid without a result in the output register");

    // A completed command always leaves the sequencer idle.
    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && step_done) |=> (r_phase == PH_IDLE))
        else $error("command completed but the bus did not return to idle");

    // The gap between slots only occurs with bits still to send.
    a_gap_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_GAP) |-> (r_bits_left != 4'd0))
        else $error("inter-slot gap with no bits left");

    // A done result never shows a busy or driven bus.
    a_done_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.done_res) |->
            (!r_out_data.busy_res && !r_out_data.drive_low))
        else $error("done result with busy or driven line");

endmodule
